// ===== src/nssr_pkg.sv =====
// package for the nibble strobe slave responder: phase codes, register indexes, widths, helpers
package nssr_pkg;

    // field widths
    localparam int NIB_W    = 4;
    localparam int ADC_W    = 10;
    localparam int TICK_W   = 16;
    localparam int IDX_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 8;

    // number of nibbles in a sample transfer, acknowledge included
    localparam logic [IDX_W-1:0] NIB_COUNT = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_CODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_CODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GET_CODE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 3'd4;

    // register reset values
    localparam logic [NIB_W-1:0]  RST_RESET_CODE    = 4'd1;
    localparam logic [NIB_W-1:0]  RST_PING_CODE     = 4'd2;
    localparam logic [NIB_W-1:0]  RST_GET_CODE      = 4'd3;
    localparam logic [NIB_W-1:0]  RST_ACK_CODE      = 4'd14;
    localparam logic [TICK_W-1:0] RST_TIMEOUT_LIMIT = 16'd1000;

    // bus protocol phase
    typedef enum logic [1:0] {
        PH_POLL = 2'd0,
        PH_READ = 2'd1,
        PH_PROC = 2'd2,
        PH_SEND = 2'd3
    } t_phase;

    // nibble of a transfer: sample low first, then the acknowledge
    function automatic logic [NIB_W-1:0] f_nibble_of(
        input logic [1:0]       idx,
        input logic [ADC_W-1:0] sample,
        input logic [NIB_W-1:0] ack
    );
        logic [NIB_W-1:0] nib;
        case (idx)
            2'd0:    nib = sample[3:0];
            2'd1:    nib = sample[7:4];
            2'd2:    nib = {2'b00, sample[9:8]};
            default: nib = ack;
        endcase
        return nib;
    endfunction

endpackage

// ===== src/nibble_strobe_slave_responder_core.sv =====
// top level of the nibble strobe slave responder: bus phase logic, result register, config
//
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   one bus sample tick
// m_axis    out        m_axis_tvalid/m_axis_tready   one result per tick
// cfg       in         i_cfg_valid/o_cfg_ready       register index and data
//
// one tick a cycle while the output register can take it: each request is worked out in the
// cycle it is taken and its result is written to the output register as it is taken; the
// phase and transfer registers are the only loop.
// a request is taken whenever the output register is empty or being emptied, so a
// stalled master side holds the input back only while its result waits.
// synchronous active-low reset restores the register defaults and the poll phase.
// the config port is always ready; writes go straight to the registers.
module nibble_strobe_slave_responder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request: [0] strobe_req, [4:1] bus_in, [14:5] adc_value, [15] zero
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [nssr_pkg::IN_W-1:0]         s_axis_tdata,
    // result: [0] bus_drive, [4:1] bus_out, [5] timed_out, [7:6] zero
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [nssr_pkg::OUT_W-1:0]        m_axis_tdata,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nssr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nssr_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    // configuration registers
    logic [nssr_pkg::NIB_W-1:0]  r_reset_code;
    logic [nssr_pkg::NIB_W-1:0]  r_ping_code;
    logic [nssr_pkg::NIB_W-1:0]  r_get_code;
    logic [nssr_pkg::NIB_W-1:0]  r_ack_code;
    logic [nssr_pkg::TICK_W-1:0] r_timeout_limit;

    // protocol state
    nssr_pkg::t_phase            r_phase, n_phase;
    logic                        r_answer_pending, n_answer_pending;
    logic [nssr_pkg::NIB_W-1:0]  r_command, n_command;
    logic [nssr_pkg::IDX_W-1:0]  r_nibble_index, n_nibble_index;
    logic                        r_seen_high, n_seen_high;
    logic [nssr_pkg::TICK_W-1:0] r_tick_count, n_tick_count;
    logic [nssr_pkg::ADC_W-1:0]  r_held_sample, n_held_sample;
    logic [nssr_pkg::NIB_W-1:0]  r_out_nibble, n_out_nibble;

    // result register
    logic                        r_out_valid;
    logic                        r_drive, n_drive;
    logic [nssr_pkg::NIB_W-1:0]  r_bus_out, n_bus_out;
    logic                        r_timed_out, n_timed_out;

    // request fields
    logic                        in_strobe;
    logic [nssr_pkg::NIB_W-1:0]  in_bus;
    logic [nssr_pkg::ADC_W-1:0]  in_adc;
    logic                        in_accept;

    // transfer tick working values
    logic                        is_start, is_send, is_ack_cmd, is_get_cmd;
    logic                        t_seen;
    logic [nssr_pkg::IDX_W-1:0]  t_idx, t_idx_adv;
    logic [nssr_pkg::TICK_W-1:0] t_tc;
    logic [nssr_pkg::ADC_W-1:0]  t_hs;
    logic [nssr_pkg::NIB_W-1:0]  t_outn;
    logic                        t_timeout;

    assign in_strobe = s_axis_tdata[0];
    assign in_bus    = s_axis_tdata[4:1];
    assign in_adc    = s_axis_tdata[14:5];

    // handshakes
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // command decode, reset code first, then ping, then get
    assign is_ack_cmd = (r_command == r_reset_code) || (r_command == r_ping_code);
    assign is_get_cmd = !is_ack_cmd && (r_command == r_get_code);
    assign is_start   = (r_phase == nssr_pkg::PH_PROC) && is_get_cmd;
    assign is_send    = (r_phase == nssr_pkg::PH_SEND) || is_start;

    // transfer tick: a new transfer begins from a freshly latched sample
    always_comb begin
        t_hs      = is_start ? in_adc : r_held_sample;
        t_idx     = is_start ? '0 : r_nibble_index;
        t_seen    = is_start ? 1'b0 : r_seen_high;
        t_tc      = is_start ? '0 : r_tick_count;
        t_outn    = is_start ? nssr_pkg::f_nibble_of(2'd0, in_adc, r_ack_code) : r_out_nibble;
        t_idx_adv = t_idx;
        if (!in_strobe && t_seen && (t_idx < nssr_pkg::NIB_COUNT)) begin
            t_idx_adv = t_idx + 1'b1;
        end
        t_timeout = (t_tc >= r_timeout_limit);
    end

    // next state
    always_comb begin
        n_phase          = r_phase;
        n_answer_pending = r_answer_pending;
        n_command        = r_command;
        n_nibble_index   = r_nibble_index;
        n_seen_high      = r_seen_high;
        n_tick_count     = r_tick_count;
        n_held_sample    = r_held_sample;
        n_out_nibble     = r_out_nibble;
        case (r_phase)
            nssr_pkg::PH_POLL: begin
                if (in_strobe) begin
                    n_phase = r_answer_pending ? nssr_pkg::PH_PROC : nssr_pkg::PH_READ;
                end
            end
            nssr_pkg::PH_READ: begin
                if (!in_strobe) begin
                    n_answer_pending = 1'b1;
                    n_phase          = nssr_pkg::PH_POLL;
                end else begin
                    n_command = in_bus;
                end
            end
            default: begin
                if (r_phase == nssr_pkg::PH_PROC && is_ack_cmd) begin
                    if (in_strobe) begin
                        n_out_nibble = r_ack_code;
                    end else begin
                        n_phase          = nssr_pkg::PH_POLL;
                        n_answer_pending = 1'b0;
                    end
                end else if (is_send) begin
                    n_held_sample  = t_hs;
                    n_nibble_index = t_idx_adv;
                    n_out_nibble   = t_outn;
                    n_phase        = nssr_pkg::PH_SEND;
                    if (in_strobe) begin
                        n_seen_high = 1'b1;
                    end else begin
                        n_seen_high = t_seen ? 1'b0 : t_seen;
                        if (t_seen && (t_idx_adv < nssr_pkg::NIB_COUNT)) begin
                            n_out_nibble = nssr_pkg::f_nibble_of(t_idx_adv[1:0], t_hs,
                                                                 r_ack_code);
                        end
                    end
                    n_tick_count = t_timeout ? '0 : t_tc + 1'b1;
                    if (t_timeout || (t_idx_adv >= nssr_pkg::NIB_COUNT)) begin
                        n_phase          = nssr_pkg::PH_POLL;
                        n_answer_pending = 1'b0;
                    end
                end else begin
                    // unknown command: back to polling for a new one
                    n_phase          = nssr_pkg::PH_POLL;
                    n_answer_pending = 1'b0;
                end
            end
        endcase
    end

    // result of the tick
    always_comb begin
        n_drive     = (r_phase == nssr_pkg::PH_SEND) ||
                      ((r_phase == nssr_pkg::PH_PROC) && (is_ack_cmd || is_get_cmd));
        n_bus_out   = n_drive ? n_out_nibble : '0;
        n_timed_out = is_send && t_timeout;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_code    <= nssr_pkg::RST_RESET_CODE;
            r_ping_code     <= nssr_pkg::RST_PING_CODE;
            r_get_code      <= nssr_pkg::RST_GET_CODE;
            r_ack_code      <= nssr_pkg::RST_ACK_CODE;
            r_timeout_limit <= nssr_pkg::RST_TIMEOUT_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                nssr_pkg::CFG_RESET_CODE:    r_reset_code    <= i_cfg_data[3:0];
                nssr_pkg::CFG_PING_CODE:     r_ping_code     <= i_cfg_data[3:0];
                nssr_pkg::CFG_GET_CODE:      r_get_code      <= i_cfg_data[3:0];
                nssr_pkg::CFG_ACK_CODE:      r_ack_code      <= i_cfg_data[3:0];
                nssr_pkg::CFG_TIMEOUT_LIMIT: r_timeout_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // protocol state update on each request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= nssr_pkg::PH_POLL;
            r_answer_pending <= 1'b0;
            r_command        <= '0;
            r_nibble_index   <= '0;
            r_seen_high      <= 1'b0;
            r_tick_count     <= '0;
            r_held_sample    <= '0;
            r_out_nibble     <= '0;
        end else if (in_accept) begin
            r_phase          <= n_phase;
            r_answer_pending <= n_answer_pending;
            r_command        <= n_command;
            r_nibble_index   <= n_nibble_index;
            r_seen_high      <= n_seen_high;
            r_tick_count     <= n_tick_count;
            r_held_sample    <= n_held_sample;
            r_out_nibble     <= n_out_nibble;
        end
    end

    // output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_drive     <= n_drive;
            r_bus_out   <= n_bus_out;
            r_timed_out <= n_timed_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_timed_out, r_bus_out, r_drive};

    // a timeout only happens while the slave drives the bus
    a_timeout_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_timed_out) |-> r_drive)
        else $error("timeout reported while bus not driven");

    // an undriven bus reads as zero
    a_idle_bus_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_drive) |-> (r_bus_out == '0))
        else $error("bus_out not zero while undriven");

    // a timed-out transfer returns to polling
    a_timeout_polls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_timed_out) |=> (r_phase == nssr_pkg::PH_POLL && !r_answer_pending))
        else $error("transfer continued after timeout");

    // nibble index never runs past the acknowledge
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nibble_index <= nssr_pkg::NIB_COUNT)
        else $error("nibble index past the last nibble");

endmodule
